@@ sv/torus_curve_waveshaper_unit_macros.svh @@
// Assertion macros for the curve waveshaper top level.
// Included by torus_curve_waveshaper_unit.sv; needs clk and rst_n in scope.
`ifndef TORUS_CURVE_WAVESHAPER_UNIT_MACROS_SVH
`define TORUS_CURVE_WAVESHAPER_UNIT_MACROS_SVH

// Condition holds, then the property holds in the same cycle.
`define TCW_ASSERT_IMPLY(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("torus_curve_waveshaper_unit: same-cycle check failed");

// Condition holds, then the property holds in the next cycle.
`define TCW_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("torus_curve_waveshaper_unit: next-cycle check failed");

`endif

@@ sv/tcw_pkg.sv @@
// Shared types and constants of the curve waveshaper.
// No dependencies; imported by the shaper, gain and top-level modules.
`default_nettype none
package tcw_pkg;

    localparam int V_W       = 48;
    localparam int SUM_W     = 15;
    localparam int GAIN_W    = 27;
    localparam int DRIVE_W   = 12;
    localparam int DIV1_Q_W  = 18;
    localparam int DIV2_Q_W  = 17;
    localparam int SIN_LAT   = 4;
    localparam int SHAPE_LAT = 1 + DIV1_Q_W + 4 + DIV2_Q_W + 1;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [GAIN_W-1:0] gain;
    } shape_cfg_t;

endpackage
`default_nettype wire

@@ sv/tcw_sin.sv @@
// Pipelined Q14 sine from a 16-bit angle, quarter-wave polynomial, four stages.
// No dependencies.
`default_nettype none
module tcw_sin #(
    parameter int TRIG_BITS = 10
) (
    input  logic               clk,
    input  logic [15:0]        angle,
    output logic signed [15:0] value
);

    localparam logic [15:0] KEEP = 16'hFFFF << (16 - TRIG_BITS);

    logic [15:0] ang_m;
    logic [14:0] x_next;
    logic [14:0] x1_reg;
    logic [29:0] xsq_reg;
    logic        neg1_reg;

    logic [14:0] x2_next;
    logic [24:0] cprod;
    logic [13:0] t_next;
    logic [14:0] x2_reg;
    logic [14:0] xb_reg;
    logic [13:0] t_reg;
    logic        neg2_reg;

    logic [28:0] p3;
    logic [14:0] u_next;
    logic [14:0] u_reg;
    logic [14:0] xc_reg;
    logic        neg3_reg;

    logic [29:0] p4;
    logic [15:0] s_mag;
    logic signed [15:0] value_reg;

    always_comb
    begin
        ang_m  = angle & KEEP;
        x_next = ang_m[14] ? 15'(15'd16384 - {1'b0, ang_m[13:0]}) : {1'b0, ang_m[13:0]};
    end

    always_ff @(posedge clk)
    begin
        x1_reg   <= x_next;
        xsq_reg  <= 30'(x_next) * 30'(x_next);
        neg1_reg <= ang_m[15];
    end

    always_comb
    begin
        x2_next = 15'((xsq_reg + 30'd8192) >> 14);
        cprod   = 25'(x2_next) * 25'd1160;
        t_next  = 14'(14'd10512 - 14'((cprod + 25'd8192) >> 14));
    end

    always_ff @(posedge clk)
    begin
        x2_reg   <= x2_next;
        xb_reg   <= x1_reg;
        t_reg    <= t_next;
        neg2_reg <= neg1_reg;
    end

    always_comb
    begin
        p3     = 29'(x2_reg) * 29'(t_reg);
        u_next = 15'(15'd25736 - 15'((p3 + 29'd8192) >> 14));
    end

    always_ff @(posedge clk)
    begin
        u_reg    <= u_next;
        xc_reg   <= xb_reg;
        neg3_reg <= neg2_reg;
    end

    always_comb
    begin
        p4    = 30'(xc_reg) * 30'(u_reg);
        s_mag = 16'((p4 + 30'd8192) >> 14);
    end

    always_ff @(posedge clk)
    begin
        value_reg <= neg3_reg ? -$signed(s_mag) : $signed(s_mag);
    end

    assign value = value_reg;

endmodule
`default_nettype wire

@@ sv/tcw_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with side data.
// No dependencies; used twice by the shaper.
`default_nettype none
module tcw_div #(
    parameter int N_W = 31,
    parameter int D_W = 15,
    parameter int Q_W = 18,
    parameter int S_W = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    input  logic [S_W-1:0] side,
    output logic           out_valid,
    output logic [Q_W-1:0] quo,
    output logic [S_W-1:0] side_out
);

    localparam int R_W = D_W + Q_W;

    logic [R_W-1:0] rem_st  [Q_W];
    logic [D_W-1:0] den_st  [Q_W];
    logic [Q_W-1:0] q_st    [Q_W+1];
    logic [S_W-1:0] side_st [Q_W+1];
    logic           vld_st  [Q_W+1];

    assign rem_st[0]  = R_W'(num);
    assign den_st[0]  = den;
    assign q_st[0]    = '0;
    assign side_st[0] = side;
    assign vld_st[0]  = in_valid;

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        localparam int B = Q_W - 1 - k;
        logic [R_W-1:0] trial;
        logic           ge;
        logic [Q_W-1:0] q_reg;
        logic [S_W-1:0] side_reg;
        logic           vld_reg;

        assign trial = R_W'(den_st[k]) << B;
        assign ge    = rem_st[k] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                vld_reg <= vld_st[k];
            end
        end

        always_ff @(posedge clk)
        begin
            q_reg    <= q_st[k] | (ge ? (Q_W'(1) << B) : '0);
            side_reg <= side_st[k];
        end

        assign q_st[k+1]    = q_reg;
        assign side_st[k+1] = side_reg;
        assign vld_st[k+1]  = vld_reg;

        if (k < Q_W - 1)
        begin : g_carry
            logic [R_W-1:0] rem_reg;
            logic [D_W-1:0] den_reg;

            always_ff @(posedge clk)
            begin
                rem_reg <= ge ? rem_st[k] - trial : rem_st[k];
                den_reg <= den_st[k];
            end

            assign rem_st[k+1] = rem_reg;
            assign den_st[k+1] = den_reg;
        end
    end

    assign out_valid = vld_st[Q_W];
    assign quo       = q_st[Q_W];
    assign side_out  = side_st[Q_W];

endmodule
`default_nettype wire

@@ sv/tcw_gain.sv @@
// Drive gain 1 + d^3/216 in Q24, computed in four register stages.
// Depends on tcw_pkg.
`default_nettype none
module tcw_gain (
    input  logic                         clk,
    input  logic [tcw_pkg::DRIVE_W-1:0]  drive,
    output logic [tcw_pkg::GAIN_W-1:0]   gain
);

    import tcw_pkg::*;

    // Reciprocal of 27 scaled by 2^37, exact for any 32-bit dividend.
    localparam logic [32:0] RECIP27 = 33'd5090331611;

    logic [DRIVE_W-1:0] d_c;
    logic [DRIVE_W-1:0] d1_reg;
    logic [23:0]        dd_reg;
    logic [34:0]        cube;
    logic [31:0]        y_reg;
    logic [48:0]        ph_reg;
    logic [48:0]        pl_reg;
    logic [64:0]        total;
    logic [GAIN_W-1:0]  gain_reg;

    assign d_c  = (drive > 12'd2816) ? 12'd2816 : drive;
    assign cube = 35'(dd_reg) * 35'(d1_reg) + 35'd108;

    always_ff @(posedge clk)
    begin
        d1_reg <= d_c;
        dd_reg <= 24'(d_c) * 24'(d_c);
        y_reg  <= cube[34:3];
        ph_reg <= 49'(y_reg[31:16]) * 49'(RECIP27);
        pl_reg <= 49'(y_reg[15:0]) * 49'(RECIP27);
    end

    assign total = (65'(ph_reg) << 16) + 65'(pl_reg);

    always_ff @(posedge clk)
    begin
        gain_reg <= GAIN_W'(27'd16777216 + 27'(total >> 37));
    end

    assign gain = gain_reg;

endmodule
`default_nettype wire

@@ sv/tcw_shape.sv @@
// Per-coordinate shaper: normalize by R+r, apply gain, clamp, soft clip to Q15.
// Depends on tcw_pkg and tcw_div.
`default_nettype none
module tcw_shape (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [tcw_pkg::V_W-1:0]    v,
    input  tcw_pkg::shape_cfg_t               cfg,
    output logic                              out_valid,
    output logic signed [15:0]                y
);

    import tcw_pkg::*;

    localparam logic [21:0] SHAPE_K = 22'd1769472;

    logic [V_W-1:0]      mag;
    logic [V_W-1:0]      biased;
    logic                d0_valid_reg;
    logic [30:0]         d0_num_reg;
    logic                d0_neg_reg;

    logic                q1_valid;
    logic [DIV1_Q_W-1:0] q1;
    logic                q1_neg;

    logic                e1_valid_reg;
    logic                e1_neg_reg;
    logic [44:0]         e1_prod_reg;

    logic [20:0]         m_round;
    logic                e2_valid_reg;
    logic                e2_neg_reg;
    logic [17:0]         e2_m_reg;

    logic                e3_valid_reg;
    logic                e3_neg_reg;
    logic [17:0]         e3_m_reg;
    logic [35:0]         e3_sq_reg;

    logic [19:0]         x2;
    logic [21:0]         kx;
    logic                e4_valid_reg;
    logic                e4_neg_reg;
    logic [39:0]         e4_num_reg;
    logic [22:0]         e4_den_reg;

    logic                q2_valid;
    logic [DIV2_Q_W-1:0] q2;
    logic                q2_neg;
    logic [14:0]         y_mag;
    logic                out_valid_reg;
    logic signed [15:0]  y_reg;

    assign mag    = v[V_W-1] ? V_W'(-v) : V_W'(v);
    assign biased = mag + V_W'({cfg.sum, 11'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d0_valid_reg  <= 1'b0;
            e1_valid_reg  <= 1'b0;
            e2_valid_reg  <= 1'b0;
            e3_valid_reg  <= 1'b0;
            e4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            d0_valid_reg  <= in_valid;
            e1_valid_reg  <= q1_valid;
            e2_valid_reg  <= e1_valid_reg;
            e3_valid_reg  <= e2_valid_reg;
            e4_valid_reg  <= e3_valid_reg;
            out_valid_reg <= q2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        d0_num_reg <= biased[42:12];
        d0_neg_reg <= v[V_W-1];
    end

    tcw_div #(
        .N_W (31),
        .D_W (SUM_W),
        .Q_W (DIV1_Q_W),
        .S_W (1)
    ) u_div_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d0_valid_reg),
        .num       (d0_num_reg),
        .den       (cfg.sum),
        .side      (d0_neg_reg),
        .out_valid (q1_valid),
        .quo       (q1),
        .side_out  (q1_neg)
    );

    assign m_round = 21'((e1_prod_reg + 45'd8388608) >> 24);
    assign x2      = 20'((e3_sq_reg + 36'd32768) >> 16);
    assign kx      = SHAPE_K + 22'(x2);

    always_ff @(posedge clk)
    begin
        e1_neg_reg  <= q1_neg;
        e1_prod_reg <= 45'(q1) * 45'(cfg.gain);
        e2_neg_reg  <= e1_neg_reg;
        e2_m_reg    <= (m_round > 21'd196608) ? 18'd196608 : m_round[17:0];
        e3_neg_reg  <= e2_neg_reg;
        e3_m_reg    <= e2_m_reg;
        e3_sq_reg   <= 36'(e2_m_reg) * 36'(e2_m_reg);
        e4_neg_reg  <= e3_neg_reg;
        e4_num_reg  <= 40'(e3_m_reg) * 40'(kx);
        e4_den_reg  <= 23'(SHAPE_K) + 23'(x2) * 23'd9;
    end

    tcw_div #(
        .N_W (39),
        .D_W (24),
        .Q_W (DIV2_Q_W),
        .S_W (1)
    ) u_div_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (e4_valid_reg),
        .num       (39'(e4_num_reg + 40'(e4_den_reg))),
        .den       ({e4_den_reg, 1'b0}),
        .side      (e4_neg_reg),
        .out_valid (q2_valid),
        .quo       (q2),
        .side_out  (q2_neg)
    );

    assign y_mag = (q2 > 17'd32767) ? 15'h7FFF : q2[14:0];

    always_ff @(posedge clk)
    begin
        y_reg <= q2_neg ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});
    end

    assign out_valid = out_valid_reg;
    assign y         = y_reg;

endmodule
`default_nettype wire

@@ sv/torus_curve_waveshaper_unit.sv @@
// Top level of the curve waveshaper: configuration, trig front end, shapers.
// Depends on tcw_pkg, tcw_sin, tcw_gain, tcw_shape and the macro header.
`default_nettype none
`include "torus_curve_waveshaper_unit_macros.svh"
// Usage:
// A request is accepted at each rising edge where start is high and busy is low.
// busy stays low: the pipeline takes one phase pair in every cycle.
// Each request yields one point; done is high for exactly one cycle while
// x_out, y_out and z_out hold it.
// The latency is set by the two bit-per-stage dividers in each shaper (18 and
// 17 stages), the four-stage sine units and the product stages around them.
// Results come out in request order and cannot be held off by the receiver.
// Configuration writes use cfg_we, cfg_index and cfg_data and take effect at
// once; the user must make them while no request is in flight, since the
// block does not enforce it. The gain follows drive writes through tcw_gain.
// Reset clears all valid bits and loads the register defaults: electron
// family, radius difference 10, both windings 1, drive 0.
// Only the low 16 bits of each phase set the angle; whole turns drop out.
module torus_curve_waveshaper_unit #(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [20:0]        big_phase,
    input  logic [20:0]        little_phase,
    output logic               done,
    output logic signed [15:0] x_out,
    output logic signed [15:0] y_out,
    output logic signed [15:0] z_out,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [14:0]        cfg_data
);

    import tcw_pkg::*;

    localparam logic [2:0] REG_EQ_SELECT   = 3'd0;
    localparam logic [2:0] REG_RADIAL_DIFF = 3'd1;
    localparam logic [2:0] REG_BIG_WIND    = 3'd2;
    localparam logic [2:0] REG_LITTLE_WIND = 3'd3;
    localparam logic [2:0] REG_DRIVE       = 3'd4;

    localparam logic [1:0] EQ_ELECTRON = 2'd0;
    localparam logic [1:0] EQ_FOLDING  = 2'd1;
    localparam logic [1:0] EQ_TORUS    = 2'd2;
    localparam logic [1:0] EQ_NONE     = 2'd3;

    localparam int A_TC0 = 0;
    localparam int A_TC1 = 1;
    localparam int A_TS0 = 2;
    localparam int A_TS1 = 3;
    localparam int A_TN0 = 4;
    localparam int A_TN1 = 5;
    localparam int A_NC0 = 6;
    localparam int A_NC1 = 7;
    localparam int A_NS0 = 8;
    localparam int A_NS1 = 9;
    localparam int A_CB  = 10;
    localparam int A_SB  = 11;
    localparam int A_CL  = 12;
    localparam int A_SL  = 13;
    localparam int NUM_TRIG = 14;

    localparam int TOP_STAGES = 2 + SIN_LAT + 3;
    localparam int LATENCY    = TOP_STAGES + SHAPE_LAT;

    localparam logic [15:0] QUARTER = 16'h4000;

    function automatic logic [15:0] wind_angle(input logic [15:0] ph, input logic [2:0] n);
        logic [18:0] p;
        begin
            p = 19'(ph) * 19'(n);
            return p[15:0];
        end
    endfunction

    function automatic logic signed [15:0] blend_q14(input logic [7:0] f,
                                                     input logic signed [15:0] t0,
                                                     input logic signed [15:0] t1);
        logic signed [25:0] v;
        logic [25:0]        m;
        logic [17:0]        r;
        begin
            v = $signed({18'b0, f}) * 26'(t1)
                + $signed({17'b0, 9'(9'd256 - {1'b0, f})}) * 26'(t0);
            m = v[25] ? 26'(-v) : 26'(v);
            r = 18'((m + 26'd128) >> 8);
            return v[25] ? -$signed(r[15:0]) : $signed(r[15:0]);
        end
    endfunction

    function automatic logic signed [15:0] rnd_q14(input logic signed [31:0] v);
        logic [31:0] m;
        logic [17:0] r;
        begin
            m = v[31] ? 32'(-v) : 32'(v);
            r = 18'((m + 32'd8192) >> 14);
            return v[31] ? -$signed(r[15:0]) : $signed(r[15:0]);
        end
    endfunction

    // Configuration registers.
    logic [1:0]         eq_sel_reg;
    logic signed [14:0] rad_diff_reg;
    logic [10:0]        big_wind_reg;
    logic [10:0]        little_wind_reg;
    logic [11:0]        drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eq_sel_reg      <= EQ_ELECTRON;
            rad_diff_reg    <= 15'sd2560;
            big_wind_reg    <= 11'd256;
            little_wind_reg <= 11'd256;
            drive_reg       <= 12'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EQ_SELECT:   eq_sel_reg      <= cfg_data[1:0];
                REG_RADIAL_DIFF: rad_diff_reg    <= $signed(cfg_data);
                REG_BIG_WIND:    big_wind_reg    <= cfg_data[10:0];
                REG_LITTLE_WIND: little_wind_reg <= cfg_data[10:0];
                REG_DRIVE:       drive_reg       <= cfg_data[11:0];
                default:         ;
            endcase
        end
    end

    logic [10:0]        bw_c;
    logic [10:0]        lw_c;
    logic signed [14:0] rd_c;
    logic signed [15:0] r_wide;
    logic signed [15:0] sum_wide;
    logic [14:0]        r_val;
    logic [2:0]         tn;
    logic [2:0]         nn;
    logic [7:0]         tf;
    logic [7:0]         nf;
    shape_cfg_t         shape_cfg;
    logic [GAIN_W-1:0]  gain;

    always_comb
    begin
        bw_c = (big_wind_reg > 11'd1280) ? 11'd1280 : big_wind_reg;
        lw_c = (little_wind_reg > 11'd1280) ? 11'd1280 : little_wind_reg;
        if (rad_diff_reg < -15'sd2560)
        begin
            rd_c = -15'sd2560;
        end
        else if (rad_diff_reg > 15'sd11520)
        begin
            rd_c = 15'sd11520;
        end
        else
        begin
            rd_c = rad_diff_reg;
        end
        r_wide   = 16'sd11520 - 16'(rd_c);
        sum_wide = 16'sd23040 - 16'(rd_c);
        r_val    = r_wide[14:0];
        tn       = bw_c[10:8];
        tf       = bw_c[7:0];
        nn       = lw_c[10:8];
        nf       = lw_c[7:0];
    end

    tcw_gain u_gain (
        .clk   (clk),
        .drive (drive_reg),
        .gain  (gain)
    );

    assign shape_cfg.sum  = sum_wide[SUM_W-1:0];
    assign shape_cfg.gain = gain;

    // Valid bits of the front-end stages.
    logic vld_reg [TOP_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOP_STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int i = 1; i < TOP_STAGES; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Input capture and angle generation.
    logic [15:0] bp_reg;
    logic [15:0] lp_reg;
    logic [15:0] ang_next [NUM_TRIG];
    logic [15:0] ang_reg  [NUM_TRIG];

    always_ff @(posedge clk)
    begin
        bp_reg <= big_phase[15:0];
        lp_reg <= little_phase[15:0];
    end

    always_comb
    begin
        ang_next[A_TS0] = wind_angle(bp_reg, tn);
        ang_next[A_TS1] = wind_angle(bp_reg, 3'(tn + 3'd1));
        ang_next[A_TC0] = ang_next[A_TS0] + QUARTER;
        ang_next[A_TC1] = ang_next[A_TS1] + QUARTER;
        ang_next[A_TN0] = wind_angle(bp_reg, nn);
        ang_next[A_TN1] = wind_angle(bp_reg, 3'(nn + 3'd1));
        ang_next[A_NS0] = wind_angle(lp_reg, nn);
        ang_next[A_NS1] = wind_angle(lp_reg, 3'(nn + 3'd1));
        ang_next[A_NC0] = ang_next[A_NS0] + QUARTER;
        ang_next[A_NC1] = ang_next[A_NS1] + QUARTER;
        ang_next[A_SB]  = bp_reg;
        ang_next[A_CB]  = bp_reg + QUARTER;
        ang_next[A_SL]  = lp_reg;
        ang_next[A_CL]  = lp_reg + QUARTER;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_TRIG; i++)
        begin
            ang_reg[i] <= ang_next[i];
        end
    end

    logic signed [15:0] trig [NUM_TRIG];

    for (genvar g = 0; g < NUM_TRIG; g++)
    begin : g_trig
        tcw_sin #(
            .TRIG_BITS (TRIG_TABLE_BITS)
        ) u_sin (
            .clk   (clk),
            .angle (ang_reg[g]),
            .value (trig[g])
        );
    end

    // Winding blends.
    logic signed [15:0] tc_reg;
    logic signed [15:0] ts_reg;
    logic signed [15:0] tns_reg;
    logic signed [15:0] nc_reg;
    logic signed [15:0] ns_reg;
    logic signed [15:0] cb_reg;
    logic signed [15:0] sb_reg;
    logic signed [15:0] cl_reg;
    logic signed [15:0] sl_reg;

    always_ff @(posedge clk)
    begin
        tc_reg  <= blend_q14(tf, trig[A_TC0], trig[A_TC1]);
        ts_reg  <= blend_q14(tf, trig[A_TS0], trig[A_TS1]);
        tns_reg <= blend_q14(tf, trig[A_TN0], trig[A_TN1]);
        nc_reg  <= blend_q14(nf, trig[A_NC0], trig[A_NC1]);
        ns_reg  <= blend_q14(nf, trig[A_NS0], trig[A_NS1]);
        cb_reg  <= trig[A_CB];
        sb_reg  <= trig[A_SB];
        cl_reg  <= trig[A_CL];
        sl_reg  <= trig[A_SL];
    end

    // Radius terms and angle products.
    logic signed [15:0] r_s;
    logic signed [31:0] rnc;
    logic signed [31:0] a0_reg;
    logic signed [31:0] a2_reg;
    logic signed [31:0] rns_reg;
    logic signed [15:0] p1_reg;
    logic signed [15:0] p2_reg;
    logic signed [15:0] tc7_reg;
    logic signed [15:0] ts7_reg;
    logic signed [15:0] tns7_reg;
    logic signed [15:0] cb7_reg;
    logic signed [15:0] sb7_reg;

    assign r_s = $signed({1'b0, r_val});
    assign rnc = 32'(r_s) * 32'(nc_reg);

    always_ff @(posedge clk)
    begin
        a0_reg   <= 32'sd11520 * 32'(tc_reg) + rnc;
        a2_reg   <= 32'sd188743680 + rnc;
        rns_reg  <= 32'(r_s) * 32'(ns_reg);
        p1_reg   <= rnd_q14(-(32'(cb_reg) * 32'(sl_reg)));
        p2_reg   <= rnd_q14(32'(sb_reg) * 32'(cl_reg));
        tc7_reg  <= tc_reg;
        ts7_reg  <= ts_reg;
        tns7_reg <= tns_reg;
        cb7_reg  <= cb_reg;
        sb7_reg  <= sb_reg;
    end

    // Raw coordinates per curve family.
    logic signed [V_W-1:0] vx_next;
    logic signed [V_W-1:0] vy_next;
    logic signed [V_W-1:0] vz_next;
    logic signed [V_W-1:0] vx_reg;
    logic signed [V_W-1:0] vy_reg;
    logic signed [V_W-1:0] vz_reg;

    always_comb
    begin
        case (eq_sel_reg)
            EQ_ELECTRON:
            begin
                vx_next = V_W'(a0_reg) * V_W'(cb7_reg);
                vy_next = V_W'(a0_reg) * V_W'(sb7_reg);
                vz_next = V_W'(rns_reg) * V_W'(tns7_reg);
            end
            EQ_FOLDING:
            begin
                vx_next = V_W'(a0_reg) * V_W'(p1_reg);
                vy_next = V_W'(a0_reg) * V_W'(p2_reg);
                vz_next = V_W'(rns_reg) * V_W'(tc7_reg);
            end
            EQ_TORUS:
            begin
                vx_next = V_W'(a2_reg) * V_W'(tc7_reg);
                vy_next = V_W'(a2_reg) * V_W'(ts7_reg);
                vz_next = (V_W'(rns_reg) + (V_W'(cb7_reg) <<< 8)) <<< 14;
            end
            default:
            begin
                vx_next = '0;
                vy_next = '0;
                vz_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        vx_reg <= vx_next;
        vy_reg <= vy_next;
        vz_reg <= vz_next;
    end

    logic x_valid;
    logic y_valid;
    logic z_valid;

    tcw_shape u_shape_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[TOP_STAGES-1]),
        .v         (vx_reg),
        .cfg       (shape_cfg),
        .out_valid (x_valid),
        .y         (x_out)
    );

    tcw_shape u_shape_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[TOP_STAGES-1]),
        .v         (vy_reg),
        .cfg       (shape_cfg),
        .out_valid (y_valid),
        .y         (y_out)
    );

    tcw_shape u_shape_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[TOP_STAGES-1]),
        .v         (vz_reg),
        .cfg       (shape_cfg),
        .out_valid (z_valid),
        .y         (z_out)
    );

    assign done = x_valid && y_valid && z_valid;
    assign busy = 1'b0;

    `TCW_ASSERT_IMPLY(a_latency, done, $past(start && !busy, LATENCY))
    `TCW_ASSERT_IMPLY(a_out_range, done, x_out != -16'sd32768 && y_out != -16'sd32768 && z_out != -16'sd32768)
    `TCW_ASSERT_NEXT(a_family_off, vld_reg[TOP_STAGES-2] && eq_sel_reg == EQ_NONE, vx_reg == '0 && vy_reg == '0 && vz_reg == '0)

endmodule
`default_nettype wire
